/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks that are switched off while reset is held
`define TCCW_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checks that also hold across reset
`define TCCW_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/tccw_pkg.sv */
package tccw_pkg;

    localparam int COLS     = 80;
    localparam int ROWS     = 25;
    localparam int CELLS    = COLS * ROWS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int TAB_STEP = 8;

    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CELL_W  = 16;
    localparam int COLOR_W = 8;

    localparam logic [CELL_W-1:0]  RESET_BLANK = 16'h0720;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // apb: byte address bits, word index is the top bit
    localparam int   CFG_ADDR_W    = 3;
    localparam logic CFG_IDX_COLOR = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT   = 2'd0,
        KIND_SET   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  target_row;
        logic [COL_W-1:0]  target_col;
    } t_item;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [CELL_W-1:0] cell_value;
        logic              did_scroll;
    } t_result;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_mem_rd;

endpackage

/* hdl/text_console_cursor_writer.sv */
// channel   | direction | handshake                       | payload
// ----------+-----------+---------------------------------+-----------------
// command   | in        | start high while busy low       | i_item (t_item)
// result    | out       | o_done, one cycle, no back-off  | o_result
// register  | in/out    | apb write: psel penable pwrite  | pwdata/prdata
//
// put (no scroll) and set cursor: result registered, a new item may follow at once
// read cell: result from S_READ, after the registered read of the screen memory
// put with scroll: one cell per cycle through the single write port (copy sweep
//   then blank of the bottom row)
// clear screen: every cell blanked in S_CLEAR; after reset a clearing pass over
//   all ROWS*COLS cells (2000) runs with busy high, register writes still taken
// results are strobed for one cycle; the receiver cannot stall them
`include "assert_macros.svh"

module text_console_cursor_writer
    import tccw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  t_item                 i_item,
    // result channel
    output logic                  o_done,
    output t_result               o_result,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // sized forms of the geometry
    localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLS);
    localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'(CELLS - COLS);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLS - 1);
    localparam logic [COL_W:0]    COLS_WIDE  = (COL_W + 1)'(COLS);
    localparam logic [ROW_W:0]    ROWS_WIDE  = (ROW_W + 1)'(ROWS);
    localparam logic [COL_W:0]    TAB_ADD    = (COL_W + 1)'(TAB_STEP);
    localparam logic [COL_W:0]    TAB_MASK   = ~((COL_W + 1)'(TAB_STEP - 1));

    typedef enum logic [2:0] {
        S_INIT,   // clearing pass after reset
        S_IDLE,
        S_READ,   // waiting for the cell read
        S_CLEAR,  // blanking the whole screen
        S_COPY,   // scroll: moving rows up by one
        S_BLANK   // scroll: blanking the bottom row
    } t_state;

    t_state             r_state;
    logic [ADDR_W-1:0]  r_idx;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [COLOR_W-1:0] r_color;
    logic               r_done;
    t_result            r_out;

    logic               accept;
    logic               cfg_wr;
    logic [CELL_W-1:0]  blank;
    logic [CELL_W-1:0]  rdata;
    t_mem_wr            wr;
    t_mem_rd            rd;

    // put-character evaluation
    logic [COL_W:0]     p_col;
    logic [ROW_W:0]     p_row;
    logic [COL_W-1:0]   p_wcol;
    logic [CELL_W-1:0]  p_wdata;
    logic               p_wr;
    logic               p_scroll;
    logic [ADDR_W-1:0]  p_addr;

    // clamped target for set cursor and read cell
    logic [ROW_W-1:0]   t_row;
    logic [COL_W-1:0]   t_col;
    logic [ADDR_W-1:0]  t_addr;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign blank  = {r_color, CH_SPACE};
    assign cfg_wr = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (paddr[CFG_ADDR_W-1] == CFG_IDX_COLOR) ? {24'd0, r_color} : 32'd0;

    assign o_done   = r_done;
    assign o_result = r_out;

    assign t_row  = (i_item.target_row > ROW_LAST) ? ROW_LAST : i_item.target_row;
    assign t_col  = (i_item.target_col > COL_LAST) ? COL_LAST : i_item.target_col;
    assign t_addr = ADDR_W'(t_row) * COLS_A + ADDR_W'(t_col);

    // cursor movement for a put, with line wrap and scroll detection
    always_comb begin
        p_col    = {1'b0, r_col};
        p_row    = {1'b0, r_row};
        p_wcol   = r_col;
        p_wdata  = {r_color, i_item.char_code};
        p_wr     = 1'b0;
        p_scroll = 1'b0;
        case (i_item.char_code)
            CH_LF: begin
                p_col = '0;
                p_row = {1'b0, r_row} + 1'b1;
            end
            CH_CR: begin
                p_col = '0;
            end
            CH_TAB: begin
                p_col = ({1'b0, r_col} + TAB_ADD) & TAB_MASK;
            end
            CH_BS: begin
                // no wrap back to the previous line
                if (r_col != '0) begin
                    p_col   = {1'b0, r_col} - 1'b1;
                    p_wcol  = r_col - 1'b1;
                    p_wdata = blank;
                    p_wr    = 1'b1;
                end
            end
            default: begin
                p_col = {1'b0, r_col} + 1'b1;
                p_wr  = 1'b1;
            end
        endcase
        if (p_col >= COLS_WIDE) begin
            p_col = '0;
            p_row = p_row + 1'b1;
        end
        if (p_row >= ROWS_WIDE) begin
            p_row    = {1'b0, ROW_LAST};
            p_scroll = 1'b1;
        end
    end

    assign p_addr = ADDR_W'(r_row) * COLS_A + ADDR_W'(p_wcol);

    // memory port selection
    always_comb begin
        wr = '0;
        rd = '0;
        case (r_state)
            S_IDLE: begin
                if (accept && i_item.kind == KIND_PUT && p_wr) begin
                    wr = '{en: 1'b1, addr: p_addr, data: p_wdata};
                end
                if (accept && i_item.kind == KIND_READ) begin
                    rd = '{en: 1'b1, addr: t_addr};
                end
            end
            S_INIT: begin
                wr = '{en: 1'b1, addr: r_idx, data: RESET_BLANK};
            end
            S_CLEAR, S_BLANK: begin
                wr = '{en: 1'b1, addr: r_idx, data: blank};
            end
            S_COPY: begin
                // read one row below, write it back in the next cycle
                if (r_idx != '0) begin
                    wr = '{en: 1'b1, addr: r_idx - 1'b1, data: rdata};
                end
                if (r_idx != COPY_END) begin
                    rd = '{en: 1'b1, addr: r_idx + COLS_A};
                end
            end
            default: begin
                wr = '0;
                rd = '0;
            end
        endcase
    end

    tccw_screen_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_rd    (rd),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_idx   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_color <= COLOR_RESET;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (cfg_wr && paddr[CFG_ADDR_W-1] == CFG_IDX_COLOR) begin
                r_color <= pwdata[COLOR_W-1:0];
            end
            case (r_state)
                S_INIT: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == CELL_LAST) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        case (i_item.kind)
                            KIND_PUT: begin
                                r_row <= p_row[ROW_W-1:0];
                                r_col <= p_col[COL_W-1:0];
                                if (p_scroll) begin
                                    r_idx   <= '0;
                                    r_state <= S_COPY;
                                end else begin
                                    r_done <= 1'b1;
                                    r_out  <= '{cursor_row: p_row[ROW_W-1:0],
                                                cursor_col: p_col[COL_W-1:0],
                                                cell_value: '0,
                                                did_scroll: 1'b0};
                                end
                            end
                            KIND_SET: begin
                                r_row  <= t_row;
                                r_col  <= t_col;
                                r_done <= 1'b1;
                                r_out  <= '{cursor_row: t_row, cursor_col: t_col,
                                            cell_value: '0, did_scroll: 1'b0};
                            end
                            KIND_CLEAR: begin
                                r_row   <= '0;
                                r_col   <= '0;
                                r_idx   <= '0;
                                r_state <= S_CLEAR;
                            end
                            KIND_READ: begin
                                r_state <= S_READ;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_done  <= 1'b1;
                    r_out   <= '{cursor_row: r_row, cursor_col: r_col,
                                 cell_value: rdata, did_scroll: 1'b0};
                    r_state <= S_IDLE;
                end
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == CELL_LAST) begin
                        r_idx   <= '0;
                        r_done  <= 1'b1;
                        r_out   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_COPY: begin
                    // last copy write lands here; blanking starts at this index
                    if (r_idx == COPY_END) begin
                        r_state <= S_BLANK;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_BLANK: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == CELL_LAST) begin
                        r_idx   <= '0;
                        r_done  <= 1'b1;
                        r_out   <= '{cursor_row: r_row, cursor_col: r_col,
                                     cell_value: '0, did_scroll: 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `TCCW_CHECK_ALWAYS(a_busy_after_reset, !i_rst_n |=> busy, "busy low after reset")
    `TCCW_CHECK(a_wr_in_range, wr.en |-> (wr.addr <= CELL_LAST), "write beyond screen")
    `TCCW_CHECK(a_cursor_in_range, (r_row <= ROW_LAST) && (r_col <= COL_LAST), "cursor off screen")
    `TCCW_CHECK(a_read_interlock, (accept && i_item.kind == KIND_READ) |=> (busy && !o_done), "read not held")
    `TCCW_CHECK(a_scroll_after_sweep, (o_done && o_result.did_scroll) |-> $past(r_state == S_BLANK), "scroll item early")

endmodule

/* hdl/tccw_screen_mem.sv */
module tccw_screen_mem
    import tccw_pkg::*;
(
    input  logic              i_clk,
    input  t_mem_wr           i_wr,
    input  t_mem_rd           i_rd,
    output logic [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rdata <= mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* test/text_console_cursor_writer_test.sv */
module text_console_cursor_writer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tccw_pkg::*;

    // run limit: every item as a full scroll sweep with the longest gap, several times over
    localparam int LIMIT_NS = 300_000_000;
    localparam logic [CFG_ADDR_W-1:0] COLOR_ADDR = {CFG_IDX_COLOR, 2'b00};

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    logic          busy;
    t_item         cmd_item = '0;
    logic          o_done;
    t_result       o_result;
    logic          psel    = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]   pwdata  = '0;
    logic [31:0]   prdata;
    logic          pready;

    // shadow copy of the console: screen, cursor and attribute register
    logic [CELL_W-1:0]  shadow_screen [CELLS];
    int                 shadow_row   = 0;
    int                 shadow_col   = 0;
    logic [COLOR_W-1:0] shadow_color = COLOR_RESET;

    t_result pending_results [$];
    int      mismatch_count = 0;
    bit      no_gaps        = 1'b0;

    text_console_cursor_writer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (cmd_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // works out the result of one accepted item and moves the shadow state on
    function automatic t_result apply_command(input t_item it);
        t_result           res;
        int                trow;
        int                tcol;
        logic [CELL_W-1:0] blank;
        res   = '0;
        blank = {shadow_color, CH_SPACE};
        // out-of-range coordinates clamp to the last row and column
        trow  = (it.target_row > ROWS - 1) ? ROWS - 1 : int'(it.target_row);
        tcol  = (it.target_col > COLS - 1) ? COLS - 1 : int'(it.target_col);
        case (it.kind)
            KIND_PUT: begin
                if (it.char_code == CH_LF) begin
                    shadow_col = 0;
                    shadow_row++;
                end else if (it.char_code == CH_CR) begin
                    shadow_col = 0;
                end else if (it.char_code == CH_TAB) begin
                    shadow_col = (shadow_col + TAB_STEP) & ~(TAB_STEP - 1);
                end else if (it.char_code == CH_BS) begin
                    // backspace stops at column 0, never goes to the line above
                    if (shadow_col > 0) begin
                        shadow_col--;
                        shadow_screen[shadow_row * COLS + shadow_col] = blank;
                    end
                end else begin
                    shadow_screen[shadow_row * COLS + shadow_col] = {shadow_color, it.char_code};
                    shadow_col++;
                end
                // line wrap, also when a tab runs past the end
                if (shadow_col >= COLS) begin
                    shadow_col = 0;
                    shadow_row++;
                end
                // scroll up one row, new bottom row blank
                if (shadow_row >= ROWS) begin
                    for (int i = 0; i < CELLS - COLS; i++)
                        shadow_screen[i] = shadow_screen[i + COLS];
                    for (int i = CELLS - COLS; i < CELLS; i++)
                        shadow_screen[i] = blank;
                    shadow_row     = ROWS - 1;
                    res.did_scroll = 1'b1;
                end
            end
            KIND_SET: begin
                shadow_row = trow;
                shadow_col = tcol;
            end
            KIND_CLEAR: begin
                foreach (shadow_screen[i])
                    shadow_screen[i] = blank;
                shadow_row = 0;
                shadow_col = 0;
            end
            default: begin
                res.cell_value = shadow_screen[trow * COLS + tcol];
            end
        endcase
        res.cursor_row = ROW_W'(shadow_row);
        res.cursor_col = COL_W'(shadow_col);
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // acceptance and result check in one process so that a same-cycle result
    // always finds its expectation already queued
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (start && !busy)
                pending_results.push_back(apply_command(cmd_item));
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %p", $time, o_result);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("cursor_row", 32'(want.cursor_row), 32'(o_result.cursor_row));
                    check_field("cursor_col", 32'(want.cursor_col), 32'(o_result.cursor_col));
                    check_field("cell_value", 32'(want.cell_value), 32'(o_result.cell_value));
                    check_field("did_scroll", 32'(want.did_scroll), 32'(o_result.did_scroll));
                end
            end
        end
    end

    // one item: random gap, then hold start until busy is low at an edge
    task automatic issue_command(input t_item it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_item = it;
        start    = 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        issue_command('{KIND_PUT, ch, ROW_W'($urandom), COL_W'($urandom)});
    endtask

    task automatic set_cursor(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
        issue_command('{KIND_SET, CHAR_W'($urandom), r, c});
    endtask

    task automatic read_cell(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
        issue_command('{KIND_READ, CHAR_W'($urandom), r, c});
    endtask

    task automatic clear_screen();
        issue_command('{KIND_CLEAR, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom)});
    endtask

    // sender holds off until every result is in and the block is idle
    task automatic wait_until_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
    endtask

    // apb write of the attribute register, setup then access, then read back
    task automatic write_color(input logic [COLOR_W-1:0] color);
        wait_until_drained();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = COLOR_ADDR;
        pwdata  = {24'h0, color};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_color = color;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        check_field("text_color", {24'h0, color}, prdata);
    endtask

    // screen comes out of reset blank with the reset attribute
    task automatic test_after_reset();
        read_cell(5'd0, 7'd0);
        read_cell(ROW_W'(ROWS - 1), COL_W'(COLS - 1));
    endtask

    // printable extremes and every control code
    task automatic test_control_codes();
        put_char("A");
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CH_BS);
        put_char(CH_TAB);
        put_char(CH_CR);
        put_char(CH_BS);   // at column 0, nothing happens
        put_char(CH_LF);
    endtask

    // out-of-range row and column clamp, for set and for read
    task automatic test_clamping();
        set_cursor(5'd31, 7'd127);
        read_cell(5'd31, 7'd127);
    endtask

    // line end wrap into a scroll, tab overshoot, newline on the last row
    task automatic test_wrap_and_scroll();
        put_char("Z");
        read_cell(ROW_W'(ROWS - 2), COL_W'(COLS - 1));
        set_cursor(ROW_W'(ROWS - 1), COL_W'(COLS - 5));
        put_char(CH_TAB);
        put_char(CH_LF);
    endtask

    task automatic test_clear();
        clear_screen();
        read_cell(5'd12, 7'd40);
    endtask

    // attribute extremes seen in written cells and in blanks
    task automatic test_text_color();
        write_color(8'hFF);
        set_cursor(5'd3, 7'd10);
        put_char("Q");
        put_char(CH_BS);
        read_cell(5'd3, 7'd10);
        write_color(8'h00);
        clear_screen();
        read_cell(ROW_W'(ROWS - 1), 7'd0);
    endtask

    // mostly text with line control, cursor moves biased to the bottom rows
    // so that scrolls are frequent, reads near the cursor, rare clears
    task automatic test_random_traffic();
        int                pick;
        logic [CHAR_W-1:0] ch;
        for (int phase = 0; phase < 5; phase++) begin
            write_color(COLOR_W'($urandom));
            no_gaps = (phase == 2);
            for (int n = 0; n < 400; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    case ($urandom_range(0, 19))
                        0:       ch = CH_LF;
                        1:       ch = CH_CR;
                        2:       ch = CH_TAB;
                        3:       ch = CH_BS;
                        default: ch = CHAR_W'($urandom);
                    endcase
                    put_char(ch);
                end else if (pick < 70) begin
                    if ($urandom_range(0, 1))
                        set_cursor(ROW_W'($urandom_range(ROWS - 5, ROWS - 1)),
                                   COL_W'($urandom_range(0, COLS - 1)));
                    else
                        set_cursor(ROW_W'($urandom), COL_W'($urandom));
                end else if (pick < 98) begin
                    case ($urandom_range(0, 3))
                        0, 1:    read_cell(ROW_W'(shadow_row), COL_W'($urandom_range(0, COLS - 1)));
                        2:       read_cell(ROW_W'(shadow_row > 0 ? shadow_row - 1 : 0),
                                           COL_W'($urandom_range(0, COLS - 1)));
                        default: read_cell(ROW_W'($urandom), COL_W'($urandom));
                    endcase
                end else begin
                    clear_screen();
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        foreach (shadow_screen[i])
            shadow_screen[i] = RESET_BLANK;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // first items wait out the clearing pass through busy
        test_after_reset();
        test_control_codes();
        test_clamping();
        test_wrap_and_scroll();
        test_clear();
        test_text_color();
        test_random_traffic();

        wait_until_drained();
        // room for any stray result after the last one
        repeat (CELLS + 16) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("text_console_cursor_writer: match");
        end else begin
            $display("text_console_cursor_writer: mismatch");
        end
        $finish;
    end

    initial begin
        #LIMIT_NS;
        $display("text_console_cursor_writer: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/tccw_pkg.sv
hdl/tccw_screen_mem.sv
hdl/text_console_cursor_writer.sv
test/text_console_cursor_writer_test.sv
